>>> rtl/core/zbcr_pkg.sv
// Shared types and constants of the Z80 bus cycle responder.
package zbcr_pkg;

    localparam int MEM_DEPTH_DEF = 256;

    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [31:0] CLK_COUNT_RESET   = 32'hFFFF_FFFE;
    localparam logic [31:0] CFG_CLK_NEVER     = 32'hFFFF_FFFF;
    localparam logic [31:0] CFG_STOP_CLK_RST  = 32'd40;
    localparam logic [16:0] CFG_OPC_NEVER     = 17'h1_FFFF;
    localparam logic [7:0]  CFG_ACK_RESET     = 8'hFF;
    localparam logic [3:0]  PINS_RELEASED     = 4'hF;
    localparam logic [7:0]  T_STATE_MAX       = 8'hFF;
    localparam logic [15:0] OPC_COUNT_MAX     = 16'hFFFF;

    // Request pin bit positions, 1 means released.
    localparam int PIN_INT   = 0;
    localparam int PIN_NMI   = 1;
    localparam int PIN_BUSRQ = 2;
    localparam int PIN_WAIT  = 3;

    typedef enum logic [1:0] {
        OP_BUS_CLOCK = 2'd0,
        OP_RAM_LOAD  = 2'd1,
        OP_RESTART   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STOP_NONE      = 2'd0,
        STOP_M1_LIMIT  = 2'd1,
        STOP_CLK_LIMIT = 2'd2,
        STOP_HALT      = 2'd3
    } t_stop;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INT_AT    = 3'd0,
        CFG_NMI_AT    = 3'd1,
        CFG_BUSRQ_AT  = 3'd2,
        CFG_WAIT_AT   = 3'd3,
        CFG_RELEASE_AT = 3'd4,
        CFG_STOP_CLK  = 3'd5,
        CFG_STOP_OPC  = 3'd6,
        CFG_ACK_VEC   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  din;
        logic        mreq_n;
        logic        iorq_n;
        logic        rd_n;
        logic        wr_n;
        logic        m1_n;
        logic        halt_n;
    } t_item;

    typedef struct packed {
        logic [15:0] opcode_count;
        logic [7:0]  t_state;
        logic [1:0]  stop_cause;
        logic        is_running;
        logic        wait_pin_n;
        logic        busrq_pin_n;
        logic        nmi_pin_n;
        logic        int_pin_n;
        logic [7:0]  drive_data;
        logic        drive_enable;
    } t_result;

endpackage

>>> rtl/core/z80_bus_cycle_responder.sv
// Top level of the Z80 bus cycle responder: memory, interrupt acknowledge and pin scheduler.
//
// The responder stands in for memory and the interrupt controller of a Z80 under test. Each
// input word is one processor clock (sampled bus pins), a host RAM load, or a restart; each
// input word yields exactly one result word with the data bus drive, the four request pin
// levels and the run status. The block sustains one word per clock on both sides when the
// master side does not stall and no clearing pass runs. The pipeline has three registers,
// passed in order: the input register (which also holds the quotient of the RAM index
// reduction), a stage that waits for the registered RAM read, and the result register.
// A RAM write made by one word is forwarded to the following word, so back-to-back
// read-after-write is exact. After reset the RAM is cleared one entry per cycle; during
// that pass s_tready stays low. The configuration port is always ready; registers should be
// written only while no word is in flight. Register indexes follow the list: INT, NMI, BUSRQ,
// WAIT and release clock numbers, the clock limit, the M1 limit and the acknowledge vector.
module z80_bus_cycle_responder #(
    parameter int MEM_DEPTH = zbcr_pkg::MEM_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side. tdata fields from bit 0: address[15:0], data_in[23:16], mreq_n[24],
    // iorq_n[25], rd_n[26], wr_n[27], m1_n[28], halt_n[29], zero fill[31:30].
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [zbcr_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser fields from bit 0: operation[1:0].
    input  logic [zbcr_pkg::IN_USER_W-1:0]     i_s_tuser,
    // Master side. tdata fields from bit 0: drive_enable[0], drive_data[8:1], int_pin_n[9],
    // nmi_pin_n[10], busrq_pin_n[11], wait_pin_n[12], is_running[13], stop_cause[15:14],
    // t_state[23:16], opcode_count[39:24].
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [zbcr_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [zbcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    localparam int AW = $clog2(MEM_DEPTH);
    // Reciprocal for the index reduction: address mod MEM_DEPTH without a divider.
    // With a 16-bit address and a 32-bit scale the rounded-up reciprocal is exact.
    localparam logic [28:0] RECIP = 29'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1)
                                        / 64'(MEM_DEPTH));
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_cfg_int;
    logic [31:0] r_cfg_nmi;
    logic [31:0] r_cfg_busrq;
    logic [31:0] r_cfg_wait;
    logic [31:0] r_cfg_release;
    logic [31:0] r_cfg_stop_clk;
    logic [16:0] r_cfg_stop_opc;
    logic [7:0]  r_cfg_ack;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_int      <= zbcr_pkg::CFG_CLK_NEVER;
            r_cfg_nmi      <= zbcr_pkg::CFG_CLK_NEVER;
            r_cfg_busrq    <= zbcr_pkg::CFG_CLK_NEVER;
            r_cfg_wait     <= zbcr_pkg::CFG_CLK_NEVER;
            r_cfg_release  <= zbcr_pkg::CFG_CLK_NEVER;
            r_cfg_stop_clk <= zbcr_pkg::CFG_STOP_CLK_RST;
            r_cfg_stop_opc <= zbcr_pkg::CFG_OPC_NEVER;
            r_cfg_ack      <= zbcr_pkg::CFG_ACK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (zbcr_pkg::t_cfg_idx'(i_cfg_index))
                zbcr_pkg::CFG_INT_AT:     r_cfg_int      <= i_cfg_data;
                zbcr_pkg::CFG_NMI_AT:     r_cfg_nmi      <= i_cfg_data;
                zbcr_pkg::CFG_BUSRQ_AT:   r_cfg_busrq    <= i_cfg_data;
                zbcr_pkg::CFG_WAIT_AT:    r_cfg_wait     <= i_cfg_data;
                zbcr_pkg::CFG_RELEASE_AT: r_cfg_release  <= i_cfg_data;
                zbcr_pkg::CFG_STOP_CLK:   r_cfg_stop_clk <= i_cfg_data;
                zbcr_pkg::CFG_STOP_OPC:   r_cfg_stop_opc <= i_cfg_data[16:0];
                zbcr_pkg::CFG_ACK_VEC:    r_cfg_ack      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_idx;
    logic             r_v1;
    logic             r_v2;
    logic             r_out_vld;
    logic             out_free;
    logic             s2_fire;
    logic             s2_free;
    logic             s1_adv;
    logic             in_fire;

    assign out_free   = !r_out_vld || i_m_tready;
    assign s2_fire    = r_v2 && out_free;
    assign s2_free    = !r_v2 || s2_fire;
    assign s1_adv     = r_v1 && s2_free;
    assign o_s_tready = !r_clr_busy && (!r_v1 || s1_adv);
    assign in_fire    = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Input register: unpack the word and start the index reduction
    // ------------------------------------------------------------------
    zbcr_pkg::t_item in_item;
    logic [44:0]     in_prod;
    zbcr_pkg::t_item r_s1;
    logic [12:0]     r_s1_q;

    always_comb begin
        in_item.op     = i_s_tuser[1:0];
        in_item.addr   = i_s_tdata[15:0];
        in_item.din    = i_s_tdata[23:16];
        in_item.mreq_n = i_s_tdata[24];
        in_item.iorq_n = i_s_tdata[25];
        in_item.rd_n   = i_s_tdata[26];
        in_item.wr_n   = i_s_tdata[27];
        in_item.m1_n   = i_s_tdata[28];
        in_item.halt_n = i_s_tdata[29];
    end

    // Quotient of address by MEM_DEPTH; the remainder is taken in the next stage.
    assign in_prod = 45'(in_item.addr) * 45'(RECIP);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1   <= in_item;
            r_s1_q <= in_prod[44:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: remainder, RAM read, forwarding from the word ahead
    // ------------------------------------------------------------------
    logic [31:0]     s1_qd;
    logic [15:0]     s1_rem;
    logic [AW-1:0]   s1_idx;
    zbcr_pkg::t_item r_s2;
    logic [AW-1:0]   r_s2_idx;
    logic            r_byp_hit;
    logic [7:0]      r_byp_data;
    logic            s2_wr;
    logic [7:0]      s2_wdata;

    assign s1_qd  = 32'(r_s1_q) * 32'(MEM_DEPTH);
    assign s1_rem = r_s1.addr - s1_qd[15:0];
    assign s1_idx = s1_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2       <= r_s1;
            r_s2_idx   <= s1_idx;
            r_byp_data <= s2_wdata;
        end
    end

    // ------------------------------------------------------------------
    // RAM and the clearing pass after reset
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign ram_we    = r_clr_busy || (s2_fire && s2_wr);
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_s2_idx;
    assign ram_wdata = r_clr_busy ? 8'h00 : s2_wdata;

    zbcr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s1_adv),
        .i_raddr (s1_idx),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: bus cycle response and status update
    // ------------------------------------------------------------------
    logic [31:0] r_clk_count;
    logic [7:0]  r_t_cnt;
    logic        r_prev_m1;
    logic [15:0] r_m1_cnt;
    logic [3:0]  r_pins;
    logic        r_run;
    logic [1:0]  r_cause;

    logic [31:0] n_clk_count;
    logic [7:0]  n_t_cnt;
    logic        n_prev_m1;
    logic [15:0] n_m1_cnt;
    logic [3:0]  n_pins;
    logic        n_run;
    logic [1:0]  n_cause;
    logic        drv_en;
    logic [7:0]  drv_val;
    logic [7:0]  mem_q;
    logic [7:0]  bus_val;

    // The word ahead may have written this entry while the RAM was being read.
    assign mem_q = r_byp_hit ? r_byp_data : ram_rdata;

    always_comb begin
        n_clk_count = r_clk_count;
        n_t_cnt     = r_t_cnt;
        n_prev_m1   = r_prev_m1;
        n_m1_cnt    = r_m1_cnt;
        n_pins      = r_pins;
        n_run       = r_run;
        n_cause     = r_cause;
        drv_en      = 1'b0;
        drv_val     = 8'h00;
        bus_val     = r_s2.din;
        s2_wr       = 1'b0;
        s2_wdata    = r_s2.din;

        unique case (r_s2.op)
            zbcr_pkg::OP_RAM_LOAD: begin
                s2_wr = 1'b1;
            end
            zbcr_pkg::OP_RESTART: begin
                n_clk_count = zbcr_pkg::CLK_COUNT_RESET;
                n_t_cnt     = 8'd0;
                n_prev_m1   = 1'b1;
                n_m1_cnt    = 16'd0;
                n_cause     = zbcr_pkg::STOP_NONE;
                n_run       = 1'b1;
            end
            zbcr_pkg::OP_BUS_CLOCK: begin
                if (r_run) begin
                    n_clk_count = r_clk_count + 32'd1;
                    if (r_t_cnt != zbcr_pkg::T_STATE_MAX) begin
                        n_t_cnt = r_t_cnt + 8'd1;
                    end
                    // Falling edge of M1 opens a new opcode fetch.
                    if (r_prev_m1 && !r_s2.m1_n) begin
                        n_t_cnt = 8'd1;
                        if (r_m1_cnt != zbcr_pkg::OPC_COUNT_MAX) begin
                            n_m1_cnt = r_m1_cnt + 16'd1;
                        end
                    end
                    n_prev_m1 = r_s2.m1_n;

                    if (!r_cfg_stop_opc[16] && (r_cfg_stop_opc[15:0] == n_m1_cnt)) begin
                        n_run   = 1'b0;
                        n_cause = zbcr_pkg::STOP_M1_LIMIT;
                    end else begin
                        if (!r_s2.mreq_n && !r_s2.rd_n) begin
                            drv_en  = 1'b1;
                            drv_val = mem_q;
                            bus_val = mem_q;
                        end else if (!r_s2.m1_n && !r_s2.iorq_n) begin
                            drv_en  = 1'b1;
                            drv_val = r_cfg_ack;
                            bus_val = r_cfg_ack;
                        end
                        if (!r_s2.mreq_n && !r_s2.wr_n) begin
                            s2_wr    = 1'b1;
                            s2_wdata = bus_val;
                        end

                        // Schedule matches only once the clock count is non-negative.
                        if (!n_clk_count[31]) begin
                            if (n_clk_count == r_cfg_int) begin
                                n_pins[zbcr_pkg::PIN_INT] = 1'b0;
                            end
                            if (n_clk_count == r_cfg_nmi) begin
                                n_pins[zbcr_pkg::PIN_NMI] = 1'b0;
                            end
                            if (n_clk_count == r_cfg_busrq) begin
                                n_pins[zbcr_pkg::PIN_BUSRQ] = 1'b0;
                            end
                            if (n_clk_count == r_cfg_wait) begin
                                n_pins[zbcr_pkg::PIN_WAIT] = 1'b0;
                            end
                            if (n_clk_count == r_cfg_release) begin
                                n_pins = zbcr_pkg::PINS_RELEASED;
                            end
                            if (n_clk_count == r_cfg_stop_clk) begin
                                n_run   = 1'b0;
                                n_cause = zbcr_pkg::STOP_CLK_LIMIT;
                            end
                            if (!r_s2.halt_n) begin
                                n_run   = 1'b0;
                                n_cause = zbcr_pkg::STOP_HALT;
                            end
                        end
                    end
                    if (!n_run) begin
                        n_pins = zbcr_pkg::PINS_RELEASED;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and status registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_vld   <= 1'b0;
            r_byp_hit   <= 1'b0;
            r_clk_count <= zbcr_pkg::CLK_COUNT_RESET;
            r_t_cnt     <= 8'd0;
            r_prev_m1   <= 1'b1;
            r_m1_cnt    <= 16'd0;
            r_pins      <= zbcr_pkg::PINS_RELEASED;
            r_run       <= 1'b0;
            r_cause     <= zbcr_pkg::STOP_NONE;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                end
            end

            if (in_fire) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end

            if (s1_adv) begin
                r_v2      <= 1'b1;
                r_byp_hit <= s2_fire && s2_wr && (r_s2_idx == s1_idx);
            end else if (s2_fire) begin
                r_v2      <= 1'b0;
                r_byp_hit <= 1'b0;
            end

            if (s2_fire) begin
                r_out_vld   <= 1'b1;
                r_clk_count <= n_clk_count;
                r_t_cnt     <= n_t_cnt;
                r_prev_m1   <= n_prev_m1;
                r_m1_cnt    <= n_m1_cnt;
                r_pins      <= n_pins;
                r_run       <= n_run;
                r_cause     <= n_cause;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    zbcr_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out.drive_enable <= drv_en;
            r_out.drive_data   <= drv_val;
            r_out.int_pin_n    <= n_pins[zbcr_pkg::PIN_INT];
            r_out.nmi_pin_n    <= n_pins[zbcr_pkg::PIN_NMI];
            r_out.busrq_pin_n  <= n_pins[zbcr_pkg::PIN_BUSRQ];
            r_out.wait_pin_n   <= n_pins[zbcr_pkg::PIN_WAIT];
            r_out.is_running   <= n_run;
            r_out.stop_cause   <= n_cause;
            r_out.t_state      <= n_t_cnt;
            r_out.opcode_count <= n_m1_cnt;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A stopped responder never holds a request pin low.
    a_stop_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.is_running) |->
        (r_out.int_pin_n && r_out.nmi_pin_n && r_out.busrq_pin_n && r_out.wait_pin_n))
        else $error("request pin held low while stopped");

    // A running responder reports no stop cause.
    a_run_no_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_cause == zbcr_pkg::STOP_NONE))
        else $error("stop cause set while running");

    // Forwarded RAM data only ever belongs to a word waiting in stage 2.
    a_byp_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_hit |-> r_v2)
        else $error("forwarding flag without a word in stage 2");

    // No word enters while the RAM is still being cleared.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_v1 && !r_v2 && !in_fire))
        else $error("word in flight during the clearing pass");

endmodule

>>> rtl/core/zbcr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module zbcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb_z80_bus_cycle_responder.sv
// Self-checking testbench of the Z80 bus cycle responder: driver, predictor and monitor.
module tb_z80_bus_cycle_responder;
    timeunit 1ns;
    timeprecision 1ps;

    import zbcr_pkg::*;

    // RAM size of the instance; the predictor reduces addresses by the same amount.
    localparam int RAM_WORDS = MEM_DEPTH_DEF;
    // Random stimulus is spread evenly over this many configuration phases.
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS = 1600;

    // Layout of a slave-side tdata word, lowest field last.
    typedef struct packed {
        logic [1:0]  pad;
        logic        halt_n;
        logic        m1_n;
        logic        wr_n;
        logic        rd_n;
        logic        iorq_n;
        logic        mreq_n;
        logic [7:0]  din;
        logic [15:0] addr;
    } t_bus_fields;

    // One word waiting to be offered on the slave side.
    typedef struct packed {
        t_op         op;
        logic [31:0] word;
    } t_pending_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata = '0;
    logic [IN_USER_W-1:0]    i_s_tuser = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [31:0]             i_cfg_data = '0;

    z80_bus_cycle_responder #(
        .MEM_DEPTH(RAM_WORDS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Words still to be offered, and responses predicted but not yet seen.
    t_pending_word pending_words[$];
    t_result       expected_responses[$];
    t_pending_word next_word;

    // Words handed to the driver and words the block has taken. The phase sequencer compares
    // these instead of looking at tvalid, which may be changing in the same time step.
    int unsigned words_sent = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    // Register values to be written at the next phase boundary.
    logic [31:0] cfg_plan[8];

    // Predictor state: its own copy of the registers, RAM, counters and pins.
    logic [31:0] cfg_img[8];
    logic [7:0]  ram_img[RAM_WORDS];
    logic [31:0] clk_cnt;
    logic [7:0]  t_cnt;
    logic        prev_m1;
    logic [15:0] m1_cnt;
    logic [3:0]  pins;
    logic        running;
    t_stop       stop_why;

    // Response to one accepted word, advancing the predictor state.
    function automatic t_result predict_bus_response(t_op op, logic [31:0] d);
        t_bus_fields b;
        t_result     r;
        logic [7:0]  bus;
        logic [7:0]  drv;
        logic        drv_en;
        int          idx;
        b = t_bus_fields'(d);
        drv = 8'd0;
        drv_en = 1'b0;
        idx = int'(b.addr) % RAM_WORDS;
        case (op)
            OP_RAM_LOAD: begin
                ram_img[idx] = b.din;
            end
            OP_RESTART: begin
                clk_cnt = CLK_COUNT_RESET;
                t_cnt = 8'd0;
                prev_m1 = 1'b1;
                m1_cnt = 16'd0;
                stop_why = STOP_NONE;
                running = 1'b1;
            end
            OP_BUS_CLOCK: begin
                if (running) begin
                    clk_cnt = clk_cnt + 32'd1;
                    if (t_cnt != T_STATE_MAX)
                        t_cnt = t_cnt + 8'd1;
                    // A falling M1 starts a new opcode fetch.
                    if (prev_m1 && !b.m1_n) begin
                        t_cnt = 8'd1;
                        if (m1_cnt != OPC_COUNT_MAX)
                            m1_cnt = m1_cnt + 16'd1;
                    end
                    prev_m1 = b.m1_n;
                    // Bit 16 of the M1 limit set means the limit is off.
                    if (!cfg_img[CFG_STOP_OPC][16] && cfg_img[CFG_STOP_OPC][15:0] == m1_cnt) begin
                        running = 1'b0;
                        stop_why = STOP_M1_LIMIT;
                    end else begin
                        bus = b.din;
                        if (!b.mreq_n && !b.rd_n) begin
                            drv_en = 1'b1;
                            drv = ram_img[idx];
                            bus = drv;
                        end else if (!b.m1_n && !b.iorq_n) begin
                            drv_en = 1'b1;
                            drv = cfg_img[CFG_ACK_VEC][7:0];
                            bus = drv;
                        end
                        if (!b.mreq_n && !b.wr_n)
                            ram_img[idx] = bus;
                        // Schedules only match once the clock count is no longer negative.
                        if (!clk_cnt[31]) begin
                            if (clk_cnt == cfg_img[CFG_INT_AT])
                                pins[PIN_INT] = 1'b0;
                            if (clk_cnt == cfg_img[CFG_NMI_AT])
                                pins[PIN_NMI] = 1'b0;
                            if (clk_cnt == cfg_img[CFG_BUSRQ_AT])
                                pins[PIN_BUSRQ] = 1'b0;
                            if (clk_cnt == cfg_img[CFG_WAIT_AT])
                                pins[PIN_WAIT] = 1'b0;
                            if (clk_cnt == cfg_img[CFG_RELEASE_AT])
                                pins = PINS_RELEASED;
                            if (clk_cnt == cfg_img[CFG_STOP_CLK]) begin
                                running = 1'b0;
                                stop_why = STOP_CLK_LIMIT;
                            end
                            // HALT wins over the clock limit on the same clock.
                            if (!b.halt_n) begin
                                running = 1'b0;
                                stop_why = STOP_HALT;
                            end
                        end
                    end
                    if (!running)
                        pins = PINS_RELEASED;
                end
            end
            default: ;
        endcase
        r = '0;
        r.drive_enable = drv_en;
        r.drive_data = drv;
        r.int_pin_n = pins[PIN_INT];
        r.nmi_pin_n = pins[PIN_NMI];
        r.busrq_pin_n = pins[PIN_BUSRQ];
        r.wait_pin_n = pins[PIN_WAIT];
        r.is_running = running;
        r.stop_cause = stop_why;
        r.t_state = t_cnt;
        r.opcode_count = m1_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_response(t_result want, t_result got);
        check_field("drive_enable", 16'(want.drive_enable), 16'(got.drive_enable));
        check_field("drive_data", 16'(want.drive_data), 16'(got.drive_data));
        check_field("int_pin_n", 16'(want.int_pin_n), 16'(got.int_pin_n));
        check_field("nmi_pin_n", 16'(want.nmi_pin_n), 16'(got.nmi_pin_n));
        check_field("busrq_pin_n", 16'(want.busrq_pin_n), 16'(got.busrq_pin_n));
        check_field("wait_pin_n", 16'(want.wait_pin_n), 16'(got.wait_pin_n));
        check_field("is_running", 16'(want.is_running), 16'(got.is_running));
        check_field("stop_cause", 16'(want.stop_cause), 16'(got.stop_cause));
        check_field("t_state", 16'(want.t_state), 16'(got.t_state));
        check_field("opcode_count", want.opcode_count, got.opcode_count);
    endfunction

    function automatic logic [31:0] bus_word(logic [15:0] addr, logic [7:0] din,
                                             logic mreq_n, iorq_n, rd_n, wr_n, m1_n, halt_n);
        return {2'b00, halt_n, m1_n, wr_n, rd_n, iorq_n, mreq_n, din, addr};
    endfunction

    // Half of the addresses fall on a handful of RAM entries so that writes get read back.
    function automatic logic [15:0] pick_address();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom);
        return {8'($urandom), 4'h0, 4'($urandom)};
    endfunction

    task automatic queue_word(t_op op, logic [31:0] w);
        pending_words.push_back('{op: op, word: w});
        words_sent++;
    endtask

    // One machine cycle of a well-behaved processor, or now and then a host load or noise.
    task automatic queue_machine_cycle();
        logic [15:0] a;
        logic [7:0]  dv;
        logic [31:0] w;
        int          waits;
        int          pick;
        logic        k;
        a = pick_address();
        dv = 8'($urandom);
        waits = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            // Opcode fetch: T1 with M1, T2 read, then two refresh states.
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 1, 1, 1, 0, 1));
            repeat (waits + 1) queue_word(OP_BUS_CLOCK, bus_word(a, dv, 0, 1, 0, 1, 0, 1));
            queue_word(OP_BUS_CLOCK, bus_word(pick_address(), dv, 0, 1, 1, 1, 1, 1));
            queue_word(OP_BUS_CLOCK, bus_word(pick_address(), dv, 1, 1, 1, 1, 1, 1));
        end else if (pick < 11) begin
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 1, 1, 1, 1, 1));
            repeat (waits + 2) queue_word(OP_BUS_CLOCK, bus_word(a, dv, 0, 1, 0, 1, 1, 1));
        end else if (pick < 14) begin
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 0, 1, 1, 1, 1, 1));
            repeat (waits + 2) queue_word(OP_BUS_CLOCK, bus_word(a, dv, 0, 1, 1, 0, 1, 1));
        end else if (pick < 15) begin
            // I/O cycle: the responder must stay off the bus.
            k = 1'($urandom_range(0, 1));
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 1, 1, 1, 1, 1));
            repeat (waits + 2) queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 0, k, !k, 1, 1));
        end else if (pick < 16) begin
            // Interrupt acknowledge: M1 first, IORQ joins later, then refresh.
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 1, 1, 1, 0, 1));
            repeat (waits + 2) queue_word(OP_BUS_CLOCK, bus_word(a, dv, 1, 0, 1, 1, 0, 1));
            repeat (2) queue_word(OP_BUS_CLOCK, bus_word(pick_address(), dv, 0, 1, 1, 1, 1, 1));
        end else if (pick < 17) begin
            queue_word(OP_BUS_CLOCK, bus_word(a, dv, 0, 1, 0, 1, 0, 0));
        end else if (pick < 18) begin
            queue_word(OP_RAM_LOAD, bus_word(a, dv, 1, 1, 1, 1, 1, 1));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                w = $urandom;
                w[31:30] = 2'b00;
                w[29] = ($urandom_range(0, 3) != 0);
                queue_word(OP_BUS_CLOCK, w);
            end
        end
    endtask

    // A run of machine cycles after a restart, occasionally without the restart (a broken sequence).
    task automatic queue_session();
        if ($urandom_range(0, 9) != 0)
            queue_word(OP_RESTART, 32'($urandom) & 32'h3FFF_FFFF);
        repeat ($urandom_range(3, 40)) queue_machine_cycle();
    endtask

    // Write all eight registers back to back, the predictor following each handshake.
    task automatic apply_cfg_plan();
        for (int r = 0; r < 8; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data <= cfg_plan[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(r))
                CFG_STOP_OPC: cfg_img[r] = {15'd0, cfg_plan[r][16:0]};
                CFG_ACK_VEC:  cfg_img[r] = {24'd0, cfg_plan[r][7:0]};
                default:      cfg_img[r] = cfg_plan[r];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every word is taken and every response checked.
    task automatic drain();
        do @(posedge i_clk);
        while (words_taken != words_sent || expected_responses.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(int group);
        case (group)
            0: begin
                src_idle_pct = 18;
                snk_idle_pct = 73;
            end
            1: begin
                src_idle_pct = 73;
                snk_idle_pct = 18;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // Sender: offers the next pending word whenever the slot is free, and predicts the
    // response of each word the block accepts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_responses.push_back(predict_bus_response(t_op'(i_s_tuser), i_s_tdata));
                words_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_word = pending_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= next_word.op;
                    i_s_tdata <= next_word.word;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and compares each response with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_responses.size() == 0) begin
                    $display("%0t: response %h with none expected", $time, o_m_tdata);
                    mismatches++;
                end else begin
                    compare_response(expected_responses.pop_front(), t_result'(o_m_tdata));
                end
            end
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Phase sequencer: directed checks first, then random phases, each with its own
    // register setting, written only while nothing is in flight.
    initial begin
        int unsigned phase_start;
        for (int r = CFG_INT_AT; r <= CFG_RELEASE_AT; r++)
            cfg_img[r] = CFG_CLK_NEVER;
        cfg_img[CFG_STOP_CLK] = CFG_STOP_CLK_RST;
        cfg_img[CFG_STOP_OPC] = {15'd0, CFG_OPC_NEVER};
        cfg_img[CFG_ACK_VEC] = {24'd0, CFG_ACK_RESET};
        foreach (ram_img[i])
            ram_img[i] = 8'd0;
        clk_cnt = CLK_COUNT_RESET;
        t_cnt = 8'd0;
        prev_m1 = 1'b1;
        m1_cnt = 16'd0;
        pins = PINS_RELEASED;
        running = 1'b0;
        stop_why = STOP_NONE;
        set_idling(0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pins fall one after another from clock 3, all come back at clock 9, and a HALT on
        // the clock limit itself must win. The first clock after restart carries HALT while
        // the count is still negative, so it must not stop the run.
        cfg_plan[CFG_INT_AT] = 32'd3;
        cfg_plan[CFG_NMI_AT] = 32'd4;
        cfg_plan[CFG_BUSRQ_AT] = 32'd5;
        cfg_plan[CFG_WAIT_AT] = 32'd6;
        cfg_plan[CFG_RELEASE_AT] = 32'd9;
        cfg_plan[CFG_STOP_CLK] = 32'd12;
        cfg_plan[CFG_STOP_OPC] = CFG_CLK_NEVER;
        cfg_plan[CFG_ACK_VEC] = 32'hA5;
        apply_cfg_plan();

        queue_word(OP_RAM_LOAD, bus_word(16'hFFFF, 8'hFF, 1, 1, 1, 1, 1, 1));
        queue_word(OP_RAM_LOAD, bus_word(16'h0100, 8'h81, 0, 0, 0, 0, 0, 0));
        // Stopped: a bus clock only reports status.
        queue_word(OP_BUS_CLOCK, bus_word(16'h0000, 8'h00, 0, 0, 0, 0, 0, 0));
        queue_word(OP_RESTART, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 1, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 0, 0));
        queue_word(OP_BUS_CLOCK, bus_word(16'h00FF, 8'h00, 0, 1, 0, 1, 0, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0007, 8'h00, 0, 1, 1, 1, 1, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h1234, 8'h3C, 0, 1, 1, 0, 1, 1));
        // Read right behind the write to the same entry.
        queue_word(OP_BUS_CLOCK, bus_word(16'h0034, 8'h00, 0, 1, 0, 1, 1, 1));
        // Interrupt acknowledge, then one that also writes: the vector lands in RAM.
        queue_word(OP_BUS_CLOCK, bus_word(16'h0040, 8'h00, 1, 0, 1, 1, 0, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0042, 8'h11, 0, 0, 1, 0, 0, 1));
        queue_word(OP_RAM_LOAD, bus_word(16'h0043, 8'h99, 1, 1, 1, 1, 1, 1));
        // Read and write strobes together store the byte being driven.
        queue_word(OP_BUS_CLOCK, bus_word(16'h0042, 8'h22, 0, 1, 0, 0, 1, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0043, 8'h00, 0, 1, 0, 1, 1, 1));
        repeat (4) queue_word(OP_BUS_CLOCK, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 1, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0042, 8'h00, 0, 1, 0, 1, 1, 0));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0042, 8'h00, 0, 1, 0, 1, 1, 1));
        drain();

        // All four pins fall on clock 0, release follows on clock 1, and the first M1 hits
        // the M1 limit, which stops the clock before anything is driven.
        for (int r = CFG_INT_AT; r <= CFG_WAIT_AT; r++)
            cfg_plan[r] = 32'd0;
        cfg_plan[CFG_RELEASE_AT] = 32'd1;
        cfg_plan[CFG_STOP_CLK] = 32'h7FFF_FFFF;
        cfg_plan[CFG_STOP_OPC] = 32'd1;
        cfg_plan[CFG_ACK_VEC] = 32'h00;
        apply_cfg_plan();
        queue_word(OP_RESTART, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 1, 1));
        repeat (3) queue_word(OP_BUS_CLOCK, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 1, 1));
        queue_word(OP_BUS_CLOCK, bus_word(16'h0000, 8'h00, 0, 0, 0, 1, 0, 1));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_idling(ph / 2);
            for (int r = CFG_INT_AT; r <= CFG_RELEASE_AT; r++) begin
                case ($urandom_range(0, 4))
                    0: cfg_plan[r] = CFG_CLK_NEVER;
                    1: cfg_plan[r] = 32'd0;
                    2: cfg_plan[r] = 32'h7FFF_FFFF;
                    default: cfg_plan[r] = $urandom_range(1, 80);
                endcase
            end
            case ($urandom_range(0, 5))
                0: cfg_plan[CFG_STOP_CLK] = CFG_CLK_NEVER;
                1: cfg_plan[CFG_STOP_CLK] = 32'd0;
                2: cfg_plan[CFG_STOP_CLK] = 32'h7FFF_FFFF;
                default: cfg_plan[CFG_STOP_CLK] = $urandom_range(30, 250);
            endcase
            case ($urandom_range(0, 5))
                0: cfg_plan[CFG_STOP_OPC] = CFG_CLK_NEVER;
                1: cfg_plan[CFG_STOP_OPC] = 32'd0;
                2: cfg_plan[CFG_STOP_OPC] = 32'd65535;
                default: cfg_plan[CFG_STOP_OPC] = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 3))
                0: cfg_plan[CFG_ACK_VEC] = 32'h00;
                1: cfg_plan[CFG_ACK_VEC] = 32'hFF;
                default: cfg_plan[CFG_ACK_VEC] = $urandom_range(0, 255);
            endcase
            // Make sure the upper extremes get written at least once.
            if (ph == 0) begin
                cfg_plan[CFG_RELEASE_AT] = 32'h7FFF_FFFF;
                cfg_plan[CFG_STOP_OPC] = 32'd65535;
                cfg_plan[CFG_ACK_VEC] = 32'hFF;
            end
            // One phase runs without limits so a long stretch without M1 saturates T-state.
            if (ph == 1) begin
                cfg_plan[CFG_STOP_CLK] = CFG_CLK_NEVER;
                cfg_plan[CFG_STOP_OPC] = CFG_CLK_NEVER;
            end
            apply_cfg_plan();

            phase_start = words_sent;
            if (ph == 1) begin
                queue_word(OP_RESTART, bus_word(16'h0000, 8'h00, 1, 1, 1, 1, 1, 1));
                repeat (300)
                    queue_word(OP_BUS_CLOCK, bus_word(pick_address(), 8'($urandom),
                               1'($urandom), 1, 1'($urandom), 1'($urandom), 1, 1));
            end
            while (words_sent - phase_start < RAND_ITEMS / RAND_PHASES)
                queue_session();
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run including the RAM clearing pass.
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
